/* hw/rtl/qnm_pkg.sv */
package qnm_pkg;

	localparam int TABLE_POINTS_DEF = 512;
	localparam int SAMPLE_BITS_DEF  = 24;
	localparam int TABLE_BITS_DEF   = 18;

	localparam int PHASE_W    = 32;
	localparam int AMP_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COS_OFFSET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LO_AMPLITUDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TWO_INPUTS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_MODE  = 3'd4;

	localparam logic [PHASE_W-1:0] RST_PHASE_STEP   = 32'd0;
	localparam logic [PHASE_W-1:0] RST_COS_OFFSET   = 32'h4000_0000;
	localparam logic [AMP_W-1:0]   RST_LO_AMPLITUDE = 18'd65536;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [PHASE_W-1:0] cos_phase_offset;
		logic [AMP_W-1:0]   lo_amplitude;
		logic               two_inputs;
		logic               simple_mode;
	} cfg_t;

endpackage

/* hw/rtl/qnm_sine_rom.sv */
module qnm_sine_rom #(
	parameter int TABLE_POINTS = qnm_pkg::TABLE_POINTS_DEF,
	parameter int TABLE_BITS   = qnm_pkg::TABLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic [$clog2(TABLE_POINTS+1)-1:0]      addr,
	output logic signed [TABLE_BITS-1:0]           data_q
);

	localparam longint unsigned RomD  = 2 * TABLE_POINTS;
	localparam longint unsigned PiQ30 = 64'd3373259426;
	localparam longint          FullS = (64'sd1 <<< (TABLE_BITS - 1)) - 64'sd1;

	function automatic logic signed [TABLE_BITS-1:0] sine_entry(input int k);
		longint unsigned u;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          s;
		logic            neg;
		u   = 4 * longint'(k);
		neg = 1'b0;
		if (u > RomD) begin
			u   = u - RomD;
			neg = 1'b1;
		end
		if (2 * u > RomD) begin
			u = RomD - u;
		end
		x    = (PiQ30 * u) / RomD;
		x2   = (x * x) >> 30;
		s    = longint'(x);
		term = x;
		term = ((term * x2) >> 30) / 64'd6;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		s    = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		s    = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		s    = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd272;
		s    = s + longint'(term);
		if (s < 0) begin
			s = 0;
		end
		s = (s * FullS + (64'sd1 <<< 29)) >>> 30;
		if (neg) begin
			s = -s;
		end
		return TABLE_BITS'(s);
	endfunction

	logic signed [TABLE_BITS-1:0] tbl [0:TABLE_POINTS];

	for (genvar k = 0; k <= TABLE_POINTS; k++) begin : g_tbl
		localparam logic signed [TABLE_BITS-1:0] Entry = sine_entry(k);
		assign tbl[k] = Entry;
	end

	always_ff @(posedge clk) begin
		data_q <= tbl[addr];
	end

endmodule

/* hw/rtl/qnm_queue.sv */
module qnm_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue popped while empty");
`endif

endmodule

/* hw/rtl/qnm_front.sv */
module qnm_front #(
	parameter int TABLE_POINTS = qnm_pkg::TABLE_POINTS_DEF,
	parameter int SAMPLE_BITS  = qnm_pkg::SAMPLE_BITS_DEF,
	localparam int IW = $clog2(TABLE_POINTS + 1),
	localparam int EW = 2 * SAMPLE_BITS + 1 + 2 * IW + 2 * qnm_pkg::PHASE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qnm_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_a,
	input  logic signed [SAMPLE_BITS-1:0] sample_b,
	output logic                          push,
	output logic [EW-1:0]                 push_data,
	input  logic                          full
);

	localparam int PW      = qnm_pkg::PHASE_W;
	localparam int Quarter = TABLE_POINTS / 4;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_SIN  = 2'd1;
	localparam logic [1:0] F_COS  = 2'd2;

	logic [1:0]                    state_q;
	logic [PW-1:0]                 acc_q;
	logic signed [SAMPLE_BITS-1:0] sa_q;
	logic signed [SAMPLE_BITS-1:0] qin_q;
	logic                          simple_q;
	logic [IW-1:0]                 sidx_q;
	logic [PW-1:0]                 sfrac_q;

	logic          in_acc;
	logic [PW-1:0] ph;
	logic [PW+IW-1:0] pos;
	logic [IW:0]   qsum;
	logic [IW-1:0] cidx_simple;
	logic [IW-1:0] cidx;
	logic [PW-1:0] cfrac;

	assign in_stall = (state_q != F_IDLE);
	assign in_acc   = in_valid && (state_q == F_IDLE);

	assign ph  = (state_q == F_SIN) ? acc_q : acc_q + cfg.cos_phase_offset;
	assign pos = (PW + IW)'(ph) * (PW + IW)'(TABLE_POINTS);

	assign qsum        = (IW + 1)'(sidx_q) + (IW + 1)'(Quarter);
	assign cidx_simple = (qsum >= (IW + 1)'(TABLE_POINTS)) ?
		IW'(qsum - (IW + 1)'(TABLE_POINTS)) : qsum[IW-1:0];

	assign cidx  = simple_q ? cidx_simple : pos[PW +: IW];
	assign cfrac = simple_q ? sfrac_q : pos[PW-1:0];

	assign push      = (state_q == F_COS) && !full;
	assign push_data = {sa_q, qin_q, simple_q, sidx_q, sfrac_q, cidx, cfrac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			acc_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_acc) begin
						acc_q   <= acc_q + cfg.phase_step;
						state_q <= F_SIN;
					end
				end
				F_SIN: begin
					state_q <= F_COS;
				end
				F_COS: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sa_q     <= sample_a;
			qin_q    <= cfg.two_inputs ? sample_b : sample_a;
			simple_q <= cfg.simple_mode;
		end
		if (state_q == F_SIN) begin
			sidx_q  <= pos[PW +: IW];
			sfrac_q <= pos[PW-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_acc_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (acc_q == $past(acc_q + cfg.phase_step)) && (state_q == F_SIN))
		else $error("phase accumulator did not advance on item");
	a_push_once: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !push) else $error("item pushed twice");
`endif

endmodule

/* hw/rtl/qnm_back.sv */
module qnm_back #(
	parameter int TABLE_POINTS = qnm_pkg::TABLE_POINTS_DEF,
	parameter int SAMPLE_BITS  = qnm_pkg::SAMPLE_BITS_DEF,
	parameter int TABLE_BITS   = qnm_pkg::TABLE_BITS_DEF,
	localparam int IW = $clog2(TABLE_POINTS + 1),
	localparam int EW = 2 * SAMPLE_BITS + 1 + 2 * IW + 2 * qnm_pkg::PHASE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qnm_pkg::cfg_t                 cfg,
	input  logic                          head_valid,
	input  logic [EW-1:0]                 head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] i_out,
	output logic signed [SAMPLE_BITS-1:0] q_out
);

	localparam int SB  = SAMPLE_BITS;
	localparam int TB  = TABLE_BITS;
	localparam int FW  = qnm_pkg::PHASE_W;
	localparam int MAW = (SB > TB) ? SB + 1 : TB + 1;
	localparam int MBW = FW + 1;
	localparam int PRW = MAW + MBW;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_A0   = 4'd1;
	localparam logic [3:0] B_A1   = 4'd2;
	localparam logic [3:0] B_A2   = 4'd3;
	localparam logic [3:0] B_A3   = 4'd4;
	localparam logic [3:0] B_L0   = 4'd5;
	localparam logic [3:0] B_M0   = 4'd6;
	localparam logic [3:0] B_M1   = 4'd7;
	localparam logic [3:0] B_M2   = 4'd8;
	localparam logic [3:0] B_M3   = 4'd9;
	localparam logic [3:0] B_OUT  = 4'd10;

	function automatic logic signed [SB-1:0] sat_out(input logic signed [SB+2:0] v);
		logic [3:0] top;
		top = v[SB+2:SB-1];
		if (top == 4'b0000 || top == 4'b1111) begin
			sat_out = v[SB-1:0];
		end else if (v[SB+2]) begin
			sat_out = {1'b1, {(SB - 1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(SB - 1){1'b1}}};
		end
	endfunction

	logic [3:0]          state_q;
	logic [EW-1:0]       ent_q;
	logic signed [TB-1:0] as_q;
	logic signed [TB-1:0] ac_q;
	logic signed [TB:0]   diff_q;
	logic signed [TB-1:0] slo_q;
	logic signed [TB-1:0] clo_q;
	logic signed [SB:0]   mi_q;
	logic signed [SB+2:0] iv_q;
	logic signed [PRW-1:0] prod_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] i_q;
	logic signed [SB-1:0] q_q;

	logic signed [SB-1:0] e_sa;
	logic signed [SB-1:0] e_qin;
	logic                 e_simple;
	logic [IW-1:0]        e_sidx;
	logic [FW-1:0]        e_sfrac;
	logic [IW-1:0]        e_cidx;
	logic [FW-1:0]        e_cfrac;

	logic [IW-1:0]         rom_addr;
	logic signed [TB-1:0]  rom_q;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic                  mul_en;
	logic signed [PRW-1:0] mix_sum;
	logic signed [PRW-1:0] amp_sum;
	logic signed [TB-1:0]  lo_base;
	logic signed [TB:0]    lo_sum;
	logic signed [SB+2:0]  qv;
	logic                  out_load;

	assign {e_sa, e_qin, e_simple, e_sidx, e_sfrac, e_cidx, e_cfrac} = ent_q;

	qnm_sine_rom #(
		.TABLE_POINTS(TABLE_POINTS),
		.TABLE_BITS  (TABLE_BITS)
	) u_rom (
		.clk   (clk),
		.addr  (rom_addr),
		.data_q(rom_q)
	);

	always_comb begin
		unique case (state_q)
			B_A1:    rom_addr = e_sidx + IW'(1);
			B_A2:    rom_addr = e_cidx;
			B_A3:    rom_addr = e_cidx + IW'(1);
			default: rom_addr = e_sidx;
		endcase
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (state_q)
			B_A3: begin
				mul_a = MAW'(diff_q);
				mul_b = $signed({1'b0, e_sfrac});
			end
			B_M0: begin
				mul_a = MAW'(e_sa);
				mul_b = MBW'(slo_q);
			end
			B_M1: begin
				mul_a = MAW'(diff_q);
				mul_b = $signed({1'b0, e_cfrac});
			end
			B_M2: begin
				mul_a = MAW'(mi_q);
				mul_b = $signed({{(MBW - qnm_pkg::AMP_W){1'b0}}, cfg.lo_amplitude});
			end
			B_M3: begin
				mul_a = MAW'(e_qin);
				mul_b = MBW'(clo_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mix_sum = prod_q + (PRW'(1) <<< (TB - 2));
	assign amp_sum = prod_q + PRW'(32768);
	assign lo_base = (state_q == B_L0) ? as_q : ac_q;
	assign lo_sum  = (TB + 1)'(lo_base) + $signed(prod_q[FW +: TB + 1]);
	assign qv      = (SB + 3)'($signed(mix_sum[TB-1 +: SB + 1]));

	assign pop      = (state_q == B_IDLE) && head_valid;
	assign out_load = (state_q == B_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q) inside
				B_IDLE: begin
					if (head_valid) begin
						state_q <= B_A0;
					end
				end
				B_OUT: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				B_A0, B_A1, B_A2, B_A3, B_L0, B_M0, B_M1, B_M2, B_M3: begin
					state_q <= state_q + 4'd1;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (mul_en) begin
			prod_q <= PRW'(mul_a) * PRW'(mul_b);
		end
		unique case (state_q)
			B_A1: as_q <= rom_q;
			B_A2: diff_q <= (TB + 1)'(rom_q) - (TB + 1)'(as_q);
			B_A3: ac_q <= rom_q;
			B_L0: begin
				diff_q <= (TB + 1)'(rom_q) - (TB + 1)'(ac_q);
				slo_q  <= lo_sum[TB-1:0];
			end
			B_M1: mi_q <= $signed(mix_sum[TB-1 +: SB + 1]);
			B_M2: clo_q <= lo_sum[TB-1:0];
			B_M3: iv_q <= e_simple ? (SB + 3)'(mi_q) : $signed(amp_sum[16 +: SB + 3]);
			default: ;
		endcase
		if (out_load) begin
			i_q <= sat_out(iv_q);
			q_q <= sat_out(qv);
		end
	end

	assign out_valid = out_valid_q;
	assign i_out     = i_q;
	assign q_out     = q_q;

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == B_A0)) else $error("item popped outside idle");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && (state_q == B_IDLE))
		else $error("result not presented after load");
`endif

endmodule

/* hw/rtl/quadrature_nco_mixer_top.sv */
// Items pass front end states F_SIN, F_COS, the two-entry queue, back end states B_A0 to B_M3,
// B_OUT and the output register. The back end works on one item at a time, with its single
// shared multiplier and single sine table port (four table reads, five multiplies per item).
// The front end stalls input outside F_IDLE and waits in F_COS while the queue is full.
// Reset clears the phase accumulator, loads register defaults and empties queue and output.
module quadrature_nco_mixer_top #(
	parameter int TABLE_POINTS = qnm_pkg::TABLE_POINTS_DEF,
	parameter int SAMPLE_BITS  = qnm_pkg::SAMPLE_BITS_DEF,
	parameter int TABLE_BITS   = qnm_pkg::TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qnm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qnm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_BITS-1:0]     sample_a,
	input  logic signed [SAMPLE_BITS-1:0]     sample_b,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]     i_out,
	output logic signed [SAMPLE_BITS-1:0]     q_out
);

	localparam int IW = $clog2(TABLE_POINTS + 1);
	localparam int EW = 2 * SAMPLE_BITS + 1 + 2 * IW + 2 * qnm_pkg::PHASE_W;

	qnm_pkg::cfg_t cfg_q;

	logic          push;
	logic [EW-1:0] push_data;
	logic          full;
	logic          pop;
	logic          not_empty;
	logic [EW-1:0] head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step       <= qnm_pkg::RST_PHASE_STEP;
			cfg_q.cos_phase_offset <= qnm_pkg::RST_COS_OFFSET;
			cfg_q.lo_amplitude     <= qnm_pkg::RST_LO_AMPLITUDE;
			cfg_q.two_inputs       <= 1'b0;
			cfg_q.simple_mode      <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qnm_pkg::REG_PHASE_STEP:   cfg_q.phase_step <= cfg_data;
				qnm_pkg::REG_COS_OFFSET:   cfg_q.cos_phase_offset <= cfg_data;
				qnm_pkg::REG_LO_AMPLITUDE: cfg_q.lo_amplitude <= cfg_data[qnm_pkg::AMP_W-1:0];
				qnm_pkg::REG_TWO_INPUTS:   cfg_q.two_inputs <= cfg_data[0];
				qnm_pkg::REG_SIMPLE_MODE:  cfg_q.simple_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	qnm_front #(
		.TABLE_POINTS(TABLE_POINTS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	qnm_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head)
	);

	qnm_back #(
		.TABLE_POINTS(TABLE_POINTS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TABLE_BITS  (TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.i_out     (i_out),
		.q_out     (q_out)
	);

endmodule

/* sim/quadrature_nco_mixer_checker.sv */
`timescale 1ns / 1ps
module quadrature_nco_mixer_checker (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	input  logic                                       cfg_ready,
	input  logic [qnm_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [qnm_pkg::CFG_DATA_W-1:0]             cfg_data,
	input  logic                                       in_valid,
	input  logic                                       in_stall,
	input  logic signed [qnm_pkg::SAMPLE_BITS_DEF-1:0] sample_a,
	input  logic signed [qnm_pkg::SAMPLE_BITS_DEF-1:0] sample_b,
	input  logic                                       out_valid,
	input  logic                                       out_stall,
	input  logic signed [qnm_pkg::SAMPLE_BITS_DEF-1:0] i_out,
	input  logic signed [qnm_pkg::SAMPLE_BITS_DEF-1:0] q_out,
	output int                                         mismatches,
	output int                                         outstanding
);

	localparam int TP = qnm_pkg::TABLE_POINTS_DEF;
	localparam int SW = qnm_pkg::SAMPLE_BITS_DEF;
	localparam int TB = qnm_pkg::TABLE_BITS_DEF;
	localparam int PW = qnm_pkg::PHASE_W;

	typedef longint unsigned u64_t;
	localparam u64_t PI_Q30 = 64'd3373259426;

	typedef struct {
		logic signed [SW-1:0] i_val;
		logic signed [SW-1:0] q_val;
	} mix_out_t;

	longint             sine_tab [0:TP];
	qnm_pkg::cfg_t      regs;
	logic [PW-1:0]      lo_phase;
	mix_out_t           expected_mix [$];

	function automatic longint sine_value(input int k);
		u64_t   d, u, x, x2, term;
		longint s;
		bit     neg;
		d = 2 * TP;
		u = 4 * k;
		neg = 1'b0;
		if (u > d) begin
			u = u - d;
			neg = 1'b1;
		end
		if (2 * u > d)
			u = d - u;
		x = (PI_Q30 * u) / d;
		x2 = (x * x) >> 30;
		s = longint'(x);
		term = x;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / (u64_t'(2 * n) * u64_t'(2 * n + 1));
			if (n % 2)
				s = s - longint'(term);
			else
				s = s + longint'(term);
		end
		if (s < 0)
			s = 0;
		s = (s * ((longint'(1) << (TB - 1)) - 1) + (longint'(1) << 29)) >>> 30;
		return neg ? -s : s;
	endfunction

	initial begin
		for (int k = 0; k <= TP; k++)
			sine_tab[k] = sine_value(k);
	end

	function automatic longint table_lerp(input u64_t idx, input logic [31:0] frac);
		longint a, b;
		a = sine_tab[idx];
		b = sine_tab[idx + 1];
		return a + (((b - a) * longint'(frac)) >>> 32);
	endfunction

	function automatic longint lo_at(input logic [PW-1:0] ph);
		u64_t p;
		p = ph;
		p = p * TP;
		return table_lerp(p >> 32, p[31:0]);
	endfunction

	function automatic longint scale_mix(input longint x, input longint lo);
		return (x * lo + (longint'(1) << (TB - 2))) >>> (TB - 1);
	endfunction

	function automatic logic signed [SW-1:0] clip(input longint v);
		longint hi_lim, lo_lim;
		hi_lim = (longint'(1) << (SW - 1)) - 1;
		lo_lim = -hi_lim - 1;
		if (v > hi_lim)
			v = hi_lim;
		else if (v < lo_lim)
			v = lo_lim;
		return v[SW-1:0];
	endfunction

	function automatic mix_out_t mixer_result(input logic [PW-1:0] ph,
			input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
		u64_t        p, idx;
		logic [31:0] frac;
		longint      sa, sb, slo, clo, iv;
		mix_out_t    r;
		sa = a;
		sb = b;
		p = ph;
		p = p * TP;
		idx = p >> 32;
		frac = p[31:0];
		slo = table_lerp(idx, frac);
		if (regs.simple_mode) begin
			clo = table_lerp((idx + TP / 4) % TP, frac);
			iv = scale_mix(sa, slo);
		end else begin
			clo = lo_at(ph + regs.cos_phase_offset);
			iv = (scale_mix(sa, slo) * longint'(regs.lo_amplitude) + (longint'(1) << 15)) >>> 16;
		end
		r.i_val = clip(iv);
		r.q_val = clip(scale_mix(regs.two_inputs ? sb : sa, clo));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mix_out_t want;
		if (!arst_n) begin
			regs.phase_step = qnm_pkg::RST_PHASE_STEP;
			regs.cos_phase_offset = qnm_pkg::RST_COS_OFFSET;
			regs.lo_amplitude = qnm_pkg::RST_LO_AMPLITUDE;
			regs.two_inputs = 1'b0;
			regs.simple_mode = 1'b1;
			lo_phase = '0;
			expected_mix.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qnm_pkg::REG_PHASE_STEP:   regs.phase_step = cfg_data;
					qnm_pkg::REG_COS_OFFSET:   regs.cos_phase_offset = cfg_data;
					qnm_pkg::REG_LO_AMPLITUDE:
						regs.lo_amplitude = cfg_data[qnm_pkg::AMP_W-1:0];
					qnm_pkg::REG_TWO_INPUTS:   regs.two_inputs = cfg_data[0];
					qnm_pkg::REG_SIMPLE_MODE:  regs.simple_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_mix.size() == 0) begin
					mismatches = mismatches + 1;
					$display("%0t: unexpected item, expected none, got i_out %0d q_out %0d",
						$time, i_out, q_out);
				end else begin
					want = expected_mix.pop_front();
					if (i_out !== want.i_val) begin
						mismatches = mismatches + 1;
						$display("%0t: i_out expected %0d, got %0d", $time, want.i_val, i_out);
					end
					if (q_out !== want.q_val) begin
						mismatches = mismatches + 1;
						$display("%0t: q_out expected %0d, got %0d", $time, want.q_val, q_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				lo_phase = lo_phase + regs.phase_step;
				expected_mix.push_back(mixer_result(lo_phase, sample_a, sample_b));
			end
			outstanding <= expected_mix.size();
		end
	end

endmodule

/* sim/quadrature_nco_mixer_top_test.sv */
`timescale 1ns / 1ps
module quadrature_nco_mixer_top_test;

	localparam int SW = qnm_pkg::SAMPLE_BITS_DEF;
	localparam int IXW = qnm_pkg::CFG_IDX_W;
	localparam int DW = qnm_pkg::CFG_DATA_W;
	localparam logic [IXW-1:0] REG_UNUSED = 3'd7;
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [IXW-1:0]          cfg_index;
	logic [DW-1:0]           cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [SW-1:0]    sample_a;
	logic signed [SW-1:0]    sample_b;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [SW-1:0]    i_out;
	logic signed [SW-1:0]    q_out;
	int                      mismatches;
	int                      outstanding;
	bit                      calm = 1'b0;
	int                      gap_pct;

	quadrature_nco_mixer_top dut (.*);

	quadrature_nco_mixer_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 15);

	task automatic write_reg(input logic [IXW-1:0] idx, input logic [DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_setting(input logic [31:0] step, input logic [31:0] offs,
			input logic [31:0] amp, input logic [31:0] two, input logic [31:0] simple);
		write_reg(qnm_pkg::REG_PHASE_STEP, step);
		write_reg(qnm_pkg::REG_COS_OFFSET, offs);
		write_reg(qnm_pkg::REG_LO_AMPLITUDE, amp);
		write_reg(qnm_pkg::REG_TWO_INPUTS, two);
		write_reg(qnm_pkg::REG_SIMPLE_MODE, simple);
		write_reg(REG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	task automatic send_samples(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return SW'(int'($urandom_range(0, 63)) - 32);
			default: return SW'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 32'h0010_0000);
			3: return $urandom_range(0, 32'h0100_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h4000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_amp();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'h0003_FFFF;
			2: return 32'h0001_0000;
			3: return $urandom_range(0, 32'h0003_FFFF);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_a <= '0;
		sample_b <= '0;
		gap_pct = 15;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero step, simple mode
		send_samples('0, '0);
		send_samples(S_MAX, S_MAX);
		send_samples(S_MIN, S_MIN);
		send_samples(-1, 1);
		drain_results();

		// quarter-table step, Q from input B
		load_setting(32'h4000_0000, 32'h4000_0000, 32'h0001_0000, 32'd1, 32'd1);
		send_samples(S_MAX, S_MIN);
		send_samples(S_MIN, S_MAX);
		send_samples(pick_sample(), pick_sample());
		send_samples(pick_sample(), pick_sample());
		drain_results();

		// general mode, full amplitude (largest lo_amplitude value), Q from input A
		load_setting(32'h0123_4567, 32'h0000_0000, 32'h0003_FFFF, 32'd0, 32'd0);
		send_samples(S_MAX, '0);
		send_samples(S_MIN, '0);
		send_samples(24'h40_0000, S_MAX);
		send_samples(24'hC0_0000, S_MIN);
		drain_results();

		// wrapping step and offset, out-of-width data bits dropped
		load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFC_0000, 32'hFFFF_FFFF, 32'h0000_0002);
		send_samples(S_MAX, S_MIN);
		send_samples(S_MIN, S_MAX);
		send_samples(pick_sample(), pick_sample());
		send_samples(pick_sample(), pick_sample());
		drain_results();

		// general mode matching the simple quarter-table cosine
		load_setting(32'h0080_0001, 32'h4000_0000, 32'h0001_0000, 32'd0, 32'd0);
		send_samples(S_MAX, S_MAX);
		send_samples(S_MIN, S_MIN);
		send_samples(pick_sample(), pick_sample());
		send_samples(pick_sample(), pick_sample());

		for (int p = 0; p < 8; p++) begin
			drain_results();
			calm <= (p == 3);
			gap_pct = (p == 3) ? 0 : 15;
			load_setting(pick_step(), pick_offset(), pick_amp(),
				($urandom() & ~32'd1) | p[1], ($urandom() & ~32'd1) | p[0]);
			for (int n = 0; n < 80; n++) begin
				if (p == 5 && n == 40)
					drain_results();
				send_samples(pick_sample(), pick_sample());
			end
		end

		drain_results();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
